>>> src/chd_pkg.sv
// Package for the chunked transfer decoder: parse mode codes, end kind codes,
// the result record and byte classification helpers. No dependencies.
`default_nettype none

package chd_pkg;

    // Default width of the chunk size counter.
    localparam int unsigned SIZE_BITS_DEF = 32;

    // Parse mode codes.
    localparam logic [2:0] MODE_LEAD   = 3'd0;
    localparam logic [2:0] MODE_DIGITS = 3'd1;
    localparam logic [2:0] MODE_LINE   = 3'd2;
    localparam logic [2:0] MODE_DATA   = 3'd3;
    localparam logic [2:0] MODE_DONE   = 3'd4;

    // End kind codes.
    localparam logic [1:0] KIND_RUN      = 2'd0;
    localparam logic [1:0] KIND_FINAL    = 2'd1;
    localparam logic [1:0] KIND_NODIGITS = 2'd2;
    localparam logic [1:0] KIND_EARLY    = 2'd3;

    localparam logic [7:0] CHAR_LF = 8'h0A;

    // One result item.
    typedef struct packed {
        logic       data_valid;
        logic [7:0] out_byte;
        logic       finished;
        logic [1:0] end_kind;
        logic       size_overflow;
    } t_result;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        case (c) inside
            [8'h30:8'h39]: v = {1'b1, 4'(c - 8'h30)};
            [8'h61:8'h66]: v = {1'b1, 4'(c - 8'h57)};
            [8'h41:8'h46]: v = {1'b1, 4'(c - 8'h37)};
            default:       v = 5'd0;
        endcase
        return v;
    endfunction

    // Whitespace: TAB, LF, VT, FF, CR and space.
    function automatic logic is_space(input logic [7:0] c);
        logic s;
        s = 1'b0;
        case (c) inside
            [8'h09:8'h0D], 8'h20: s = 1'b1;
            default:              s = 1'b0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> src/chd_parse.sv
// Chunk parser: holds the parse state and forms one result per accepted byte.
// Depends on chd_pkg.
`default_nettype none

module chd_parse
    import chd_pkg::*;
#(
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_result         o_result
);

    localparam logic [SIZE_BITS-1:0] CNT_ONE = SIZE_BITS'(1);

    logic [2:0]           r_mode, n_mode;
    logic [SIZE_BITS-1:0] r_count, n_count;
    logic                 r_ovf, n_ovf;

    logic [4:0]           hex;
    logic                 was_done;
    logic [1:0]           kind;
    logic [SIZE_BITS-1:0] shifted;
    logic                 sat;

    assign hex      = hex_decode(i_byte);
    assign was_done = (r_mode >= MODE_DONE);
    // A digit would overflow when any of the top four bits is already set.
    assign sat      = |r_count[SIZE_BITS-1 -: 4];
    assign shifted  = {r_count[SIZE_BITS-5:0], hex[3:0]};

    // Next state and result for one byte.
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_ovf   = r_ovf;
        kind    = KIND_RUN;
        o_result = '0;

        unique case (r_mode)
            MODE_LEAD: begin
                if (is_space(i_byte)) begin
                    n_mode = r_mode;
                end else if (hex[4]) begin
                    n_count = SIZE_BITS'(hex[3:0]);
                    n_mode  = MODE_DIGITS;
                end else begin
                    n_mode = MODE_DONE;
                    kind   = KIND_NODIGITS;
                end
            end
            MODE_DIGITS: begin
                if (hex[4]) begin
                    if (sat) begin
                        n_count = '1;
                        n_ovf   = 1'b1;
                    end else begin
                        n_count = shifted;
                    end
                end else if (i_byte == CHAR_LF) begin
                    if (r_count == '0) begin
                        n_mode = MODE_DONE;
                        kind   = KIND_FINAL;
                    end else begin
                        n_mode = MODE_DATA;
                    end
                end else begin
                    n_mode = MODE_LINE;
                end
            end
            MODE_LINE: begin
                if (i_byte == CHAR_LF) begin
                    if (r_count == '0) begin
                        n_mode = MODE_DONE;
                        kind   = KIND_FINAL;
                    end else begin
                        n_mode = MODE_DATA;
                    end
                end
            end
            MODE_DATA: begin
                o_result.data_valid = 1'b1;
                o_result.out_byte   = i_byte;
                n_count             = r_count - CNT_ONE;
                if (r_count == CNT_ONE) begin
                    n_mode = MODE_LEAD;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase

        // A marked last byte that did not end the body itself ends it early.
        if (kind != KIND_RUN) begin
            o_result.finished = 1'b1;
            o_result.end_kind = kind;
        end else if (i_last && !was_done) begin
            o_result.finished = 1'b1;
            o_result.end_kind = KIND_EARLY;
        end
        o_result.size_overflow = n_ovf;
    end

    // State update; a last-marked byte rearms the parser.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LEAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_mode  <= MODE_LEAD;
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_mode  <= n_mode;
                r_count <= n_count;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/http_chunked_decoder_top.sv
// Top level of the chunked transfer decoder: stream ports and result register.
// Depends on chd_pkg and chd_parse.
//
//  channel   direction  tdata         tuser                                 tlast
//  s_axis    in         in_byte       -                                     end_of_input
//  m_axis    out        out_byte      data_valid, end_kind, size_overflow   finished
//
// One byte is taken per clock while the result register is free or draining;
// each byte yields one result in the cycle after. The parse state and the result
// register are the only storage, so the rate is set by combinational next-state logic.
// Reset is synchronous and active low; it returns the parser to the start of
// a size line and empties the result register.
// A held result stalls input only while the downstream side is not ready.
`default_nettype none

module http_chunked_decoder_top
    import chd_pkg::*;
#(
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // end_of_input
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [3:0]      m_axis_tuser,   // [0] data_valid, [2:1] end_kind, [3] size_overflow
    output logic            m_axis_tlast    // finished
);

    logic    accept;
    t_result result;
    t_result r_out;
    logic    r_out_valid;

    // A new request enters whenever the result register is free or draining.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    chd_parse #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_result (result)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.out_byte;
    assign m_axis_tuser  = {r_out.size_overflow, r_out.end_kind, r_out.data_valid};
    assign m_axis_tlast  = r_out.finished;

endmodule

`default_nettype wire
